// ===== rtl/ffa_pkg.sv =====
package ffa_pkg;

  localparam int OpW     = 2;
  localparam int ArgW    = 8;
  localparam int StatusW = 2;
  localparam int HandleW = 8;
  localparam int CfgW    = 8;

  localparam logic [CfgW-1:0] CellsReset = 8'd100;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC  = 2'd0,
    OP_ERASE  = 2'd1,
    OP_DEFRAG = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_GRANTED = 2'd0,
    ST_NULL    = 2'd1,
    ST_ILLEGAL = 2'd2
  } status_e;

  typedef logic [ArgW-1:0]    arg_t;
  typedef logic [HandleW-1:0] handle_t;

endpackage

// ===== rtl/ffa_if.sv =====
interface ffa_cmd_if import ffa_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [OpW-1:0] op;
  arg_t           argument;

  modport source (output valid, output op, output argument, input ready);
  modport sink   (input valid, input op, input argument, output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  handle_t            granted_handle;

  modport source (output valid, output status, output granted_handle, input ready);
  modport sink   (input valid, input status, input granted_handle, output ready);
endinterface

// ===== rtl/first_fit_block_allocator_top.sv =====
// first-fit block allocator with compaction
// commands arrive on cmd_i (op, argument), answers leave on rsp_o (status,
// granted_handle); both are valid/ready channels, a transaction moves at a
// clock edge with valid and ready high. cfg_we_i/cfg_wdata_i write mem_cells.
// alloc always answers, erase answers only when illegal, defragment never.
// one command is worked at a time; cmd_i.ready is high only while idle.
// the owner map is a single-port-read memory walked one cell per cycle:
//   alloc       : scan of up to the usable cells, then fill of the granted block
//   erase       : owner scan over all cells clearing matching cells
//   defragment  : scan over all cells packing used cells down, then a clear
//                 of the free cells above the packed blocks
//   rejected    : straight to the answer, via the freed-mark check for an erase of a handle already freed
// after reset the owner map is cleared, one cell a cycle;
// no command is taken meanwhile, config writes are.
// a finished answer sits in an output register; while the receiver stalls the
// block still takes commands until a new answer is ready, which waits until the old one leaves.
module first_fit_block_allocator_top import ffa_pkg::*; #(
  parameter int MEM_SIZE   = 128,
  parameter int MAX_HANDLE = 255
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  ffa_cmd_if.sink         cmd_i,
  ffa_rsp_if.source       rsp_o
);

  localparam int IW = (MEM_SIZE > 1) ? $clog2(MEM_SIZE) : 1;
  localparam int LW = $clog2(MEM_SIZE + 1);
  localparam int CW = (LW > ArgW) ? LW : ArgW;
  localparam int HW = (MAX_HANDLE > 1) ? $clog2(MAX_HANDLE + 1) : 1;
  localparam int NW = $clog2(MAX_HANDLE + 2);
  localparam int XW = (NW > ArgW) ? NW : ArgW;

  localparam logic [IW-1:0] LastCell   = IW'(MEM_SIZE - 1);
  localparam logic [LW-1:0] LastW      = LW'(MEM_SIZE - 1);
  localparam logic [LW-1:0] MemSizeL   = LW'(MEM_SIZE);
  localparam logic [CW-1:0] MemSizeC   = CW'(MEM_SIZE);
  localparam logic [NW-1:0] MaxHandleN = NW'(MAX_HANDLE);
  localparam logic [NW-1:0] HandleCap  = NW'(MAX_HANDLE + 1);
  localparam logic [XW-1:0] MaxHandleX = XW'(MAX_HANDLE);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_ECHK,
    S_ALLOC,
    S_FILL,
    S_ERASE,
    S_DEFRAG,
    S_RESP
  } state_e;

  state_e             state_q;
  logic [IW-1:0]      idx_q;
  logic [IW-1:0]      end_q;
  logic [LW-1:0]      w_q;
  logic [LW-1:0]      run_q;
  logic [LW-1:0]      size_q;
  logic [HW-1:0]      handle_q;
  logic [NW-1:0]      next_handle_q;
  logic [CfgW-1:0]    mem_cells_q;
  status_e            res_status_q;
  handle_t            res_handle_q;
  logic               rsp_valid_q;
  logic [StatusW-1:0] rsp_status_q;
  handle_t            rsp_handle_q;

  logic               freed_mem_q [MAX_HANDLE + 1];
  logic               freed_rd_q;
  logic               fr_we;
  logic [HW-1:0]      fr_waddr;
  logic               fr_wdata;

  logic               own_we;
  logic [IW-1:0]      own_waddr;
  logic [HW-1:0]      own_wdata;
  logic [IW-1:0]      own_raddr;
  logic [HW-1:0]      own_rdata;

  logic [CW-1:0]      cells_eff;
  logic [CW-1:0]      arg_c;
  logic [XW-1:0]      arg_x;
  logic               alloc_bad;
  logic               erase_bad;
  logic               last_alloc;
  logic               cell_free;
  logic [LW-1:0]      run_inc;
  logic [LW-1:0]      fill_start;
  logic [LW-1:0]      w_inc;
  logic [LW-1:0]      w_next;
  logic               scan_state;
  logic               rsp_load;

  assign cells_eff  = (CW'(mem_cells_q) < MemSizeC) ? CW'(mem_cells_q) : MemSizeC;
  assign arg_c      = CW'(cmd_i.argument);
  assign arg_x      = XW'(cmd_i.argument);
  assign alloc_bad  = (arg_c == '0) || (arg_c > cells_eff) || (next_handle_q > MaxHandleN);
  assign erase_bad  = (arg_x == '0) || (arg_x > MaxHandleX) || (arg_x >= XW'(next_handle_q));
  assign last_alloc = (CW'(idx_q) == (cells_eff - CW'(1)));
  assign cell_free  = (own_rdata == '0);
  assign run_inc    = cell_free ? (run_q + LW'(1)) : '0;
  assign fill_start = LW'(idx_q) + LW'(1) - size_q;
  assign w_inc      = w_q + LW'(1);
  assign w_next     = cell_free ? w_q : w_inc;
  assign scan_state = (state_q == S_ALLOC) || (state_q == S_ERASE) || (state_q == S_DEFRAG);
  assign rsp_load   = (state_q == S_RESP) && (!rsp_valid_q || rsp_o.ready);

  // read one cell ahead of the one being evaluated
  assign own_raddr = (scan_state && (idx_q != LastCell)) ? (idx_q + IW'(1)) : '0;

  always_comb begin
    own_we    = 1'b0;
    own_waddr = idx_q;
    own_wdata = '0;
    case (state_q)
      S_CLR: begin
        own_we    = 1'b1;
        own_waddr = w_q[IW-1:0];
      end
      S_FILL: begin
        own_we    = 1'b1;
        own_wdata = HW'(next_handle_q);
      end
      S_ERASE: begin
        own_we = (own_rdata == handle_q);
      end
      S_DEFRAG: begin
        own_we    = !cell_free;
        own_waddr = w_q[IW-1:0];
        own_wdata = own_rdata;
      end
      default: begin
        own_we = 1'b0;
      end
    endcase
  end

  ffa_owner_map #(
    .Depth (MEM_SIZE),
    .AW    (IW),
    .DW    (HW)
  ) u_owner_map (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (own_waddr),
    .wdata_i (own_wdata),
    .raddr_i (own_raddr),
    .rdata_o (own_rdata)
  );

  // freed marks, written at grant and at erase, read at the command argument and used only for issued handles
  assign fr_we    = ((state_q == S_FILL) && (idx_q == end_q)) ||
                    ((state_q == S_ECHK) && !freed_rd_q);
  assign fr_waddr = (state_q == S_FILL) ? HW'(next_handle_q) : handle_q;
  assign fr_wdata = (state_q == S_ECHK);

  always_ff @(posedge clk_i) begin
    if (fr_we) begin
      freed_mem_q[fr_waddr] <= fr_wdata;
    end
    freed_rd_q <= freed_mem_q[HW'(cmd_i.argument)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_cells_q <= CellsReset;
    end else if (cfg_we_i) begin
      mem_cells_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLR;
      idx_q         <= '0;
      end_q         <= '0;
      w_q           <= '0;
      run_q         <= '0;
      size_q        <= '0;
      handle_q      <= '0;
      next_handle_q <= NW'(1);
      res_status_q  <= ST_NULL;
      res_handle_q  <= '0;
      rsp_valid_q   <= 1'b0;
      rsp_status_q  <= '0;
      rsp_handle_q  <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid_q  <= 1'b1;
        rsp_status_q <= res_status_q;
        rsp_handle_q <= res_handle_q;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          if (w_q == LastW) begin
            state_q <= S_IDLE;
          end else begin
            w_q <= w_inc;
          end
        end
        S_IDLE: begin
          if (cmd_i.valid) begin
            idx_q <= '0;
            run_q <= '0;
            w_q   <= '0;
            case (cmd_i.op)
              OP_ALLOC: begin
                if (alloc_bad) begin
                  res_status_q <= ST_NULL;
                  res_handle_q <= '0;
                  state_q      <= S_RESP;
                end else begin
                  size_q  <= LW'(cmd_i.argument);
                  state_q <= S_ALLOC;
                end
              end
              OP_ERASE: begin
                if (erase_bad) begin
                  res_status_q <= ST_ILLEGAL;
                  res_handle_q <= '0;
                  state_q      <= S_RESP;
                end else begin
                  handle_q <= HW'(cmd_i.argument);
                  state_q  <= S_ECHK;
                end
              end
              OP_DEFRAG: begin
                state_q <= S_DEFRAG;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_ECHK: begin
          if (freed_rd_q) begin
            res_status_q <= ST_ILLEGAL;
            res_handle_q <= '0;
            state_q      <= S_RESP;
          end else begin
            state_q <= S_ERASE;
          end
        end
        S_ALLOC: begin
          run_q <= run_inc;
          if (run_inc == size_q) begin
            end_q   <= idx_q;
            idx_q   <= IW'(fill_start);
            state_q <= S_FILL;
          end else if (last_alloc) begin
            res_status_q <= ST_NULL;
            res_handle_q <= '0;
            state_q      <= S_RESP;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        S_FILL: begin
          if (idx_q == end_q) begin
            res_status_q  <= ST_GRANTED;
            res_handle_q  <= HandleW'(next_handle_q);
            next_handle_q <= next_handle_q + NW'(1);
            state_q       <= S_RESP;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        S_ERASE: begin
          if (idx_q == LastCell) begin
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        S_DEFRAG: begin
          w_q <= w_next;
          if (idx_q == LastCell) begin
            state_q <= (w_next == MemSizeL) ? S_IDLE : S_CLR;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        S_RESP: begin
          if (rsp_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          w_q     <= '0;
          state_q <= S_CLR;
        end
      endcase
    end
  end

  assign cmd_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.granted_handle = rsp_handle_q;

  a_fail_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != ST_GRANTED) |-> rsp_o.granted_handle == '0)
    else $error("failed answer carries a handle");

  a_handle_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_handle_q <= HandleCap)
    else $error("handle counter beyond cap");

  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_i.ready && (cmd_i.op == OP_ALLOC) |=> !cmd_i.ready)
    else $error("ready right after alloc transaction");

  a_defrag_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEFRAG) |-> (LW'(idx_q) >= w_q))
    else $error("compaction write pointer ahead of scan");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> (CW'(end_q) < cells_eff) && (idx_q <= end_q))
    else $error("fill outside usable cells");

endmodule

// ===== rtl/ffa_owner_map.sv =====
module ffa_owner_map #(
  parameter int Depth = 128,
  parameter int AW    = 7,
  parameter int DW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [Depth];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ffa_pkg::*;

  localparam int MEM_SIZE   = 128;
  localparam int MAX_HANDLE = 255;
  localparam int DRAIN_CYC  = 2 * MEM_SIZE + 50;
  localparam int CYC_LIMIT  = 1000000;
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  typedef enum bit {K_CMD, K_CFG} kind_e;

  typedef struct packed {
    kind_e          kind;
    logic [OpW-1:0] op;
    arg_t           arg;
    bit             typed;
    status_e        st;
    handle_t        h;
  } step_t;

  typedef struct {
    status_e status;
    handle_t handle;
  } answer_t;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we;
  logic [CfgW-1:0] cfg_wdata;

  ffa_cmd_if cmd ();
  ffa_rsp_if rsp ();

  first_fit_block_allocator_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .cmd_i       (cmd),
    .rsp_o       (rsp)
  );

  always #2 clk_i = ~clk_i;

  // allocator state mirror
  logic [7:0]      owner [MEM_SIZE];
  logic [6:0]      blk_start [MAX_HANDLE+1];
  logic [7:0]      blk_len [MAX_HANDLE+1];
  bit              live [MAX_HANDLE+1];
  logic [8:0]      next_handle = 9'd1;
  logic [CfgW-1:0] cells = CellsReset;

  answer_t answers_due [$];
  int      fails = 0;
  int      cyc = 0;
  int      burst_left = 0;
  int      max_gap = 8;
  int      stall_mode = 0;

  initial begin
    foreach (owner[i]) owner[i] = '0;
    foreach (live[i]) live[i] = 1'b0;
    foreach (blk_start[i]) blk_start[i] = '0;
    foreach (blk_len[i]) blk_len[i] = '0;
  end

  function automatic int usable_cells();
    return (cells < MEM_SIZE) ? int'(cells) : MEM_SIZE;
  endfunction

  task automatic predict_answer(input logic [OpW-1:0] op, input arg_t arg,
                                output bit has, output answer_t ans);
    int ncell;
    int run;
    int last;
    int w;
    int prev;
    bit found;
    logic [7:0] v;
    has = 1'b0;
    ans.status = ST_NULL;
    ans.handle = '0;
    case (op)
      OP_ALLOC: begin
        has = 1'b1;
        ncell = usable_cells();
        run = 0;
        found = 1'b0;
        last = 0;
        if (arg != 0 && int'(arg) <= ncell && next_handle <= MAX_HANDLE) begin
          for (int i = 0; i < ncell && !found; i++) begin
            run = (owner[i] == 0) ? run + 1 : 0;
            if (run == int'(arg)) begin
              found = 1'b1;
              last = i;
            end
          end
        end
        if (found) begin
          for (int k = last + 1 - int'(arg); k <= last; k++) owner[k] = next_handle[7:0];
          blk_start[next_handle[7:0]] = 7'(last + 1 - int'(arg));
          blk_len[next_handle[7:0]] = arg;
          live[next_handle[7:0]] = 1'b1;
          ans.status = ST_GRANTED;
          ans.handle = next_handle[7:0];
          next_handle = next_handle + 9'd1;
        end
      end
      OP_ERASE: begin
        if (arg == 0 || !live[arg]) begin
          has = 1'b1;
          ans.status = ST_ILLEGAL;
        end else begin
          for (int k = int'(blk_start[arg]);
               k < int'(blk_start[arg]) + int'(blk_len[arg]) && k < MEM_SIZE; k++)
            owner[k] = '0;
          live[arg] = 1'b0;
        end
      end
      OP_DEFRAG: begin
        w = 0;
        prev = 0;
        for (int i = 0; i < MEM_SIZE; i++) begin
          v = owner[i];
          if (v != 0) begin
            if (int'(v) != prev) blk_start[v] = 7'(w);
            owner[w] = v;
            w++;
          end
          prev = int'(v);
        end
        for (int i = w; i < MEM_SIZE; i++) owner[i] = '0;
      end
      default: ;
    endcase
  endtask

  function automatic arg_t pick_live();
    int s;
    s = $urandom_range(0, MAX_HANDLE);
    for (int i = 0; i <= MAX_HANDLE; i++)
      if (live[(s + i) % (MAX_HANDLE + 1)]) return arg_t'((s + i) % (MAX_HANDLE + 1));
    return '0;
  endfunction

  task automatic send_cmd(input logic [OpW-1:0] op, input arg_t arg,
                          input bit typed = 1'b0, input status_e st = ST_GRANTED,
                          input handle_t h = '0);
    int gap;
    bit has;
    answer_t ans;
    if (burst_left == 0) begin
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
        cmd.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    cmd.valid    <= 1'b1;
    cmd.op       <= op;
    cmd.argument <= arg;
    do @(posedge clk_i); while (!cmd.ready);
    burst_left--;
    predict_answer(op, arg, has, ans);
    if (typed) begin
      ans.status = st;
      ans.handle = h;
      answers_due.push_back(ans);
    end else if (has) begin
      answers_due.push_back(ans);
    end
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_cells(input logic [CfgW-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cells = value;
  endtask

  task automatic random_item();
    int r;
    int s;
    arg_t a;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      s = $urandom_range(0, 99);
      if (s < 80) a = arg_t'($urandom_range(1, 8));
      else if (s < 92) a = arg_t'($urandom_range(1, usable_cells()));
      else a = arg_t'($urandom_range(0, 255));
      send_cmd(OP_ALLOC, a);
    end else if (r < 88) begin
      a = ($urandom_range(0, 4) != 0) ? pick_live() : arg_t'($urandom_range(0, 255));
      send_cmd(OP_ERASE, a);
    end else if (r < 96) begin
      send_cmd(OP_DEFRAG, arg_t'($urandom_range(0, 255)));
    end else begin
      send_cmd(OP_UNUSED, arg_t'($urandom_range(0, 255)));
    end
  endtask

  step_t dir_tab [26] = '{
    '{K_CMD, OP_ALLOC,  8'd0,   1'b1, ST_NULL,    8'd0},
    '{K_CMD, OP_ALLOC,  8'd101, 1'b1, ST_NULL,    8'd0},
    '{K_CMD, OP_ALLOC,  8'd100, 1'b1, ST_GRANTED, 8'd1},
    '{K_CMD, OP_ALLOC,  8'd1,   1'b1, ST_NULL,    8'd0},
    '{K_CMD, OP_ERASE,  8'd0,   1'b1, ST_ILLEGAL, 8'd0},
    '{K_CMD, OP_ERASE,  8'd2,   1'b1, ST_ILLEGAL, 8'd0},
    '{K_CMD, OP_ERASE,  8'd1,   1'b0, ST_GRANTED, 8'd0},
    '{K_CMD, OP_ERASE,  8'd1,   1'b1, ST_ILLEGAL, 8'd0},
    '{K_CMD, OP_ALLOC,  8'd255, 1'b1, ST_NULL,    8'd0},
    '{K_CFG, OP_ALLOC,  8'd128, 1'b0, ST_GRANTED, 8'd0},
    '{K_CMD, OP_ALLOC,  8'd128, 1'b1, ST_GRANTED, 8'd2},
    '{K_CMD, OP_ERASE,  8'd2,   1'b0, ST_GRANTED, 8'd0},
    '{K_CMD, OP_ALLOC,  8'd3,   1'b1, ST_GRANTED, 8'd3},
    '{K_CMD, OP_ALLOC,  8'd5,   1'b1, ST_GRANTED, 8'd4},
    '{K_CMD, OP_ALLOC,  8'd2,   1'b1, ST_GRANTED, 8'd5},
    '{K_CMD, OP_ERASE,  8'd4,   1'b0, ST_GRANTED, 8'd0},
    '{K_CMD, OP_ALLOC,  8'd6,   1'b0, ST_GRANTED, 8'd0},
    '{K_CMD, OP_ALLOC,  8'd4,   1'b0, ST_GRANTED, 8'd0},
    '{K_CMD, OP_UNUSED, 8'd255, 1'b0, ST_GRANTED, 8'd0},
    '{K_CMD, OP_DEFRAG, 8'd170, 1'b0, ST_GRANTED, 8'd0},
    '{K_CFG, OP_ALLOC,  8'd1,   1'b0, ST_GRANTED, 8'd0},
    '{K_CMD, OP_ALLOC,  8'd1,   1'b0, ST_GRANTED, 8'd0},
    '{K_CMD, OP_ERASE,  8'd6,   1'b0, ST_GRANTED, 8'd0},
    '{K_CMD, OP_DEFRAG, 8'd85,  1'b0, ST_GRANTED, 8'd0},
    '{K_CFG, OP_ALLOC,  8'd255, 1'b0, ST_GRANTED, 8'd0},
    '{K_CMD, OP_ALLOC,  8'd128, 1'b0, ST_GRANTED, 8'd0}
  };

  // response checking
  always @(posedge clk_i) begin
    answer_t exp_ans;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (answers_due.size() == 0) begin
        $error("unexpected rsp transaction: status %0d handle %0d",
               rsp.status, rsp.granted_handle);
        fails++;
      end else begin
        exp_ans = answers_due.pop_front();
        if (rsp.status !== exp_ans.status) begin
          $error("status: expected %0d, actual %0d", exp_ans.status, rsp.status);
          fails++;
        end
        if (rsp.granted_handle !== exp_ans.handle) begin
          $error("granted_handle: expected %0d, actual %0d",
                 exp_ans.handle, rsp.granted_handle);
          fails++;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (cyc % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: rsp.ready <= 1'b1;
      1: rsp.ready <= ($urandom_range(0, 3) != 0);
      2: rsp.ready <= (cyc % 16 >= 5);
      default: rsp.ready <= (cyc % 128 >= 90);
    endcase
  end

  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CYC_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    int phase_cells [5];
    logic [8:0] nh_prev;
    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    cmd.valid    <= 1'b0;
    cmd.op       <= OP_ALLOC;
    cmd.argument <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == K_CFG) write_cells(dir_tab[i].arg);
      else send_cmd(dir_tab[i].op, dir_tab[i].arg, dir_tab[i].typed,
                    dir_tab[i].st, dir_tab[i].h);
    end

    phase_cells = '{128, 1, $urandom_range(2, 127), 255, 100};
    for (int p = 0; p < 5; p++) begin
      write_cells(CfgW'(phase_cells[p]));
      max_gap = (p == 2) ? 0 : $urandom_range(1, 16);
      for (int n = 0; n < 70; n++) random_item();
    end

    // run the handle counter out, then allocs must fail
    while (next_handle <= MAX_HANDLE) begin
      nh_prev = next_handle;
      send_cmd(OP_ALLOC, arg_t'($urandom_range(1, 4)));
      if (next_handle == nh_prev) send_cmd(OP_ERASE, pick_live());
    end
    repeat (4) send_cmd(OP_ALLOC, arg_t'($urandom_range(1, 4)));
    send_cmd(OP_ERASE, pick_live());
    send_cmd(OP_DEFRAG, '0);
    send_cmd(OP_ALLOC, 8'd1);

    drain();
    if (fails == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
